// ----- rtl/lbsc_pkg.sv -----
// Shared types and constants of the letterbox scaler address generator.
package lbsc_pkg;

   // Field widths fixed by the port list
   localparam int unsigned XW    = 11;  // canvas column, window width
   localparam int unsigned YW    = 10;  // canvas row, window height
   localparam int unsigned SW    = 11;  // source size and source coordinate
   localparam int unsigned AW    = 21;  // source linear address
   localparam int unsigned LEFTW = 10;
   localparam int unsigned TOPW  = 9;

   // Divider: dividend holds a product of two source-sized values
   localparam int unsigned DIVIDEND_W = 22;
   localparam int unsigned DIVISOR_W  = 11;
   localparam int unsigned DIV_STEPS  = DIVIDEND_W;
   localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [SW-1:0] MAX_SRC_WIDTH       = 11'd1920;
   localparam logic [SW-1:0] MAX_SRC_HEIGHT      = 11'd1080;
   localparam logic [YW-1:0] CANVAS_HEIGHT       = 10'd720;
   localparam logic [XW-1:0] CANVAS_WIDTH_WIDE   = 11'd1280;
   localparam logic [XW-1:0] CANVAS_WIDTH_NARROW = 11'd960;
   localparam logic          ASPECT_MODE_WIDE    = 1'b1;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ASPECT_MODE   = 2'd2;

   typedef enum logic [2:0] {
      MUL_CW_SH,
      MUL_CH_SW,
      MUL_DX_SW,
      MUL_DY_SH,
      MUL_SY_SW
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_GEOM,
      DIV_X,
      DIV_Y
   } div_sel_type;

   typedef enum logic [1:0] {
      OUT_INVALID,
      OUT_BORDER,
      OUT_PIXEL
   } out_sel_type;

   typedef struct packed {
      logic        latch_cfg;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        save_a;
      logic        fit_en;
      logic        div_start;
      div_sel_type div_sel;
      logic        geom_en;
      logic        count_clear;
      logic        count_step;
      logic        offs_en;
      logic        sx_en;
      logic        sy_en;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic cfg_invalid;
      logic border;
      logic last;
      logic div_busy;
      logic div_done;
   } status_type;

endpackage

// ----- rtl/lbsc_div.sv -----
// Restoring divider, one quotient bit per cycle.
module lbsc_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lbsc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [lbsc_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              busy,
   output logic                              done,
   output logic [lbsc_pkg::DIVIDEND_W-1:0]   quotient
);

   logic                             active_ff, active_in;
   logic                             done_ff, done_in;
   logic [lbsc_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lbsc_pkg::DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [lbsc_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [lbsc_pkg::DIVISOR_W-1:0]   dsr_ff, dsr_in;
   logic [lbsc_pkg::DIVISOR_W:0]     shifted;
   logic [lbsc_pkg::DIVISOR_W:0]     diff;
   logic                             ge;

   assign shifted = {rem_ff, quo_ff[lbsc_pkg::DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = lbsc_pkg::DIV_CNT_W'(lbsc_pkg::DIV_STEPS);
         quo_in    = dividend;
         rem_in    = '0;
         dsr_in    = divisor;
      end else if (active_ff) begin
         quo_in = {quo_ff[lbsc_pkg::DIVIDEND_W-2:0], ge};
         rem_in = ge ? diff[lbsc_pkg::DIVISOR_W-1:0] : shifted[lbsc_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == lbsc_pkg::DIV_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = active_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/lbsc_dp.sv -----
// Datapath: config registers, frame geometry, pixel counters, source math, result register.
module lbsc_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  lbsc_pkg::cmd_type           cmd,
   output lbsc_pkg::status_type        status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [lbsc_pkg::SW-1:0]     csr_data,
   output logic [lbsc_pkg::XW-1:0]     rsp_dest_x,
   output logic [lbsc_pkg::YW-1:0]     rsp_dest_y,
   output logic [lbsc_pkg::SW-1:0]     rsp_src_x,
   output logic [lbsc_pkg::SW-1:0]     rsp_src_y,
   output logic [lbsc_pkg::AW-1:0]     rsp_src_address,
   output logic                        rsp_is_border,
   output logic                        rsp_frame_invalid,
   output logic                        rsp_last_of_frame
);

   localparam int unsigned PW = lbsc_pkg::DIVIDEND_W;

   // config
   logic [lbsc_pkg::SW-1:0] cfg_sw_ff, cfg_sh_ff;
   logic                    cfg_aspect_ff;
   logic [lbsc_pkg::XW-1:0] cfg_cw;

   // latched frame geometry
   logic [lbsc_pkg::SW-1:0]    lat_sw_ff, lat_sh_ff;
   logic [lbsc_pkg::XW-1:0]    lat_cw_ff;
   logic [lbsc_pkg::XW-1:0]    ww_ff, ww_in;
   logic [lbsc_pkg::YW-1:0]    wh_ff, wh_in;
   logic [lbsc_pkg::LEFTW-1:0] left_ff;
   logic [lbsc_pkg::TOPW-1:0]  top_ff;
   logic                       fit_ff;

   // arithmetic
   logic [PW-1:0]           prod_ff, cmp_a_ff;
   logic [lbsc_pkg::SW-1:0] mul_a, mul_b;
   logic [PW-1:0]           div_dividend;
   logic [lbsc_pkg::DIVISOR_W-1:0] div_divisor;
   logic [PW-1:0]           div_quo;
   logic                    div_busy, div_done;
   logic [lbsc_pkg::XW-1:0] q_geom, q_min1;

   // counters and offsets
   logic [lbsc_pkg::XW-1:0] col_ff;
   logic [lbsc_pkg::YW-1:0] row_ff;
   logic [lbsc_pkg::XW:0]   col_inc;
   logic [lbsc_pkg::XW-1:0] dx_ff;
   logic [lbsc_pkg::YW-1:0] dy_ff;
   logic [lbsc_pkg::SW-1:0] sx_ff, sy_ff;

   logic [lbsc_pkg::XW:0]   x_end;
   logic [lbsc_pkg::YW:0]   y_end;
   logic                    in_x, in_y, last;

   // result register
   logic [lbsc_pkg::XW-1:0] o_dx_ff;
   logic [lbsc_pkg::YW-1:0] o_dy_ff;
   logic [lbsc_pkg::SW-1:0] o_sx_ff, o_sy_ff;
   logic [lbsc_pkg::AW-1:0] o_addr_ff;
   logic                    o_border_ff, o_inv_ff, o_last_ff;

   assign csr_ready = 1'b1;
   assign cfg_cw = (cfg_aspect_ff == lbsc_pkg::ASPECT_MODE_WIDE) ?
                   lbsc_pkg::CANVAS_WIDTH_WIDE : lbsc_pkg::CANVAS_WIDTH_NARROW;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff     <= '0;
         cfg_sh_ff     <= '0;
         cfg_aspect_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            lbsc_pkg::CSR_SOURCE_WIDTH:  cfg_sw_ff     <= csr_data;
            lbsc_pkg::CSR_SOURCE_HEIGHT: cfg_sh_ff     <= csr_data;
            lbsc_pkg::CSR_ASPECT_MODE:   cfg_aspect_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         lbsc_pkg::MUL_CW_SH: begin mul_a = lat_cw_ff; mul_b = lat_sh_ff; end
         lbsc_pkg::MUL_CH_SW: begin
            mul_a = lbsc_pkg::SW'(lbsc_pkg::CANVAS_HEIGHT);
            mul_b = lat_sw_ff;
         end
         lbsc_pkg::MUL_DX_SW: begin mul_a = dx_ff; mul_b = lat_sw_ff; end
         lbsc_pkg::MUL_DY_SH: begin mul_a = lbsc_pkg::SW'(dy_ff); mul_b = lat_sh_ff; end
         lbsc_pkg::MUL_SY_SW: begin mul_a = sy_ff; mul_b = lat_sw_ff; end
         default:             begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // divider operand select
   always_comb begin
      div_dividend = prod_ff;
      case (cmd.div_sel)
         lbsc_pkg::DIV_GEOM: begin
            div_dividend = fit_ff ? cmp_a_ff : prod_ff;
            div_divisor  = fit_ff ? lat_sw_ff : lat_sh_ff;
         end
         lbsc_pkg::DIV_X: div_divisor = ww_ff;
         lbsc_pkg::DIV_Y: div_divisor = lbsc_pkg::DIVISOR_W'(wh_ff);
         default:         div_divisor = ww_ff;
      endcase
   end

   lbsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // window fit: filled side takes the canvas, the other the quotient (at least 1)
   assign q_geom = div_quo[lbsc_pkg::XW-1:0];
   assign q_min1 = (q_geom == '0) ? lbsc_pkg::XW'(1) : q_geom;
   assign ww_in  = fit_ff ? lat_cw_ff : q_min1;
   assign wh_in  = fit_ff ? q_min1[lbsc_pkg::YW-1:0] : lbsc_pkg::CANVAS_HEIGHT;

   assign col_inc = {1'b0, col_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.latch_cfg) begin
         lat_sw_ff <= cfg_sw_ff;
         lat_sh_ff <= cfg_sh_ff;
         lat_cw_ff <= cfg_cw;
      end
      if (cmd.mul_en)
         prod_ff <= PW'(mul_a) * PW'(mul_b);
      if (cmd.save_a)
         cmp_a_ff <= prod_ff;
      if (cmd.fit_en)
         fit_ff <= cmp_a_ff <= prod_ff;
      if (cmd.geom_en) begin
         ww_ff   <= ww_in;
         wh_ff   <= wh_in;
         left_ff <= lbsc_pkg::LEFTW'((lat_cw_ff - ww_in) >> 1);
         top_ff  <= lbsc_pkg::TOPW'((lbsc_pkg::CANVAS_HEIGHT - wh_in) >> 1);
      end
      if (cmd.offs_en) begin
         dx_ff <= col_ff - lbsc_pkg::XW'(left_ff);
         dy_ff <= row_ff - lbsc_pkg::YW'(top_ff);
      end
      if (cmd.sx_en)
         sx_ff <= div_quo[lbsc_pkg::SW-1:0];
      if (cmd.sy_en)
         sy_ff <= div_quo[lbsc_pkg::SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.count_clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.count_step) begin
         if (col_inc >= {1'b0, lat_cw_ff}) begin
            col_ff <= '0;
            row_ff <= row_ff + 1'b1;
         end else begin
            col_ff <= col_inc[lbsc_pkg::XW-1:0];
         end
      end
   end

   assign x_end = {1'b0, ww_ff} + (lbsc_pkg::XW + 1)'(left_ff);
   assign y_end = {1'b0, wh_ff} + (lbsc_pkg::YW + 1)'(top_ff);
   assign in_x  = (col_ff >= lbsc_pkg::XW'(left_ff)) && ({1'b0, col_ff} < x_end);
   assign in_y  = (row_ff >= lbsc_pkg::YW'(top_ff)) && ({1'b0, row_ff} < y_end);
   assign last  = (col_inc >= {1'b0, lat_cw_ff}) &&
                  (({1'b0, row_ff} + 1'b1) >= {1'b0, lbsc_pkg::CANVAS_HEIGHT});

   assign status.cfg_invalid = (cfg_sw_ff == '0) || (cfg_sh_ff == '0) ||
                               (cfg_sw_ff > lbsc_pkg::MAX_SRC_WIDTH) ||
                               (cfg_sh_ff > lbsc_pkg::MAX_SRC_HEIGHT);
   assign status.border   = !(in_x && in_y);
   assign status.last     = last;
   assign status.div_busy = div_busy;
   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (cmd.out_sel)
            lbsc_pkg::OUT_PIXEL: begin
               o_dx_ff     <= col_ff;
               o_dy_ff     <= row_ff;
               o_sx_ff     <= sx_ff;
               o_sy_ff     <= sy_ff;
               o_addr_ff   <= prod_ff[lbsc_pkg::AW-1:0] + lbsc_pkg::AW'(sx_ff);
               o_border_ff <= 1'b0;
               o_inv_ff    <= 1'b0;
               o_last_ff   <= last;
            end
            lbsc_pkg::OUT_BORDER: begin
               o_dx_ff     <= col_ff;
               o_dy_ff     <= row_ff;
               o_sx_ff     <= '0;
               o_sy_ff     <= '0;
               o_addr_ff   <= '0;
               o_border_ff <= 1'b1;
               o_inv_ff    <= 1'b0;
               o_last_ff   <= last;
            end
            default: begin
               o_dx_ff     <= '0;
               o_dy_ff     <= '0;
               o_sx_ff     <= '0;
               o_sy_ff     <= '0;
               o_addr_ff   <= '0;
               o_border_ff <= 1'b0;
               o_inv_ff    <= 1'b1;
               o_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_dest_x        = o_dx_ff;
   assign rsp_dest_y        = o_dy_ff;
   assign rsp_src_x         = o_sx_ff;
   assign rsp_src_y         = o_sy_ff;
   assign rsp_src_address   = o_addr_ff;
   assign rsp_is_border     = o_border_ff;
   assign rsp_frame_invalid = o_inv_ff;
   assign rsp_last_of_frame = o_last_ff;

endmodule

// ----- rtl/lbsc_ctrl.sv -----
// Controller: sequences frame setup and per-pixel math, owns the handshakes.
module lbsc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_restart_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lbsc_pkg::cmd_type     cmd,
   input  lbsc_pkg::status_type  status
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000_0000_0000_0001,
      S_START = 16'b0000_0000_0000_0010,
      S_MULA  = 16'b0000_0000_0000_0100,
      S_MULB  = 16'b0000_0000_0000_1000,
      S_CMP   = 16'b0000_0000_0001_0000,
      S_DIVG  = 16'b0000_0000_0010_0000,
      S_WAITG = 16'b0000_0000_0100_0000,
      S_GEOM  = 16'b0000_0000_1000_0000,
      S_PIX   = 16'b0000_0001_0000_0000,
      S_MULX  = 16'b0000_0010_0000_0000,
      S_DIVX  = 16'b0000_0100_0000_0000,
      S_WAITX = 16'b0000_1000_0000_0000,
      S_DIVY  = 16'b0001_0000_0000_0000,
      S_WAITY = 16'b0010_0000_0000_0000,
      S_ADDR  = 16'b0100_0000_0000_0000,
      S_EMIT  = 16'b1000_0000_0000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic                  running_ff, running_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lbsc_pkg::out_sel_type kind_ff, kind_in;
   logic                  accept, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      running_in = running_ff;
      kind_in    = kind_ff;
      cmd        = '0;
      cmd.mul_sel = lbsc_pkg::MUL_CW_SH;
      cmd.div_sel = lbsc_pkg::DIV_GEOM;
      cmd.out_sel = kind_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_restart_frame || !running_ff) begin
                  state_in = S_START;
               end else begin
                  cmd.count_step = 1'b1;
                  state_in       = S_PIX;
               end
            end
         end
         S_START: begin
            if (status.cfg_invalid) begin
               running_in = 1'b0;
               kind_in    = lbsc_pkg::OUT_INVALID;
               state_in   = S_EMIT;
            end else begin
               cmd.latch_cfg = 1'b1;
               state_in      = S_MULA;
            end
         end
         S_MULA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lbsc_pkg::MUL_CW_SH;
            state_in    = S_MULB;
         end
         S_MULB: begin
            cmd.save_a  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lbsc_pkg::MUL_CH_SW;
            state_in    = S_CMP;
         end
         S_CMP: begin
            cmd.fit_en = 1'b1;
            state_in   = S_DIVG;
         end
         S_DIVG: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = lbsc_pkg::DIV_GEOM;
            state_in      = S_WAITG;
         end
         S_WAITG: begin
            if (status.div_done)
               state_in = S_GEOM;
         end
         S_GEOM: begin
            cmd.geom_en     = 1'b1;
            cmd.count_clear = 1'b1;
            running_in      = 1'b1;
            state_in        = S_PIX;
         end
         S_PIX: begin
            if (status.last)
               running_in = 1'b0;
            if (status.border) begin
               kind_in  = lbsc_pkg::OUT_BORDER;
               state_in = S_EMIT;
            end else begin
               cmd.offs_en = 1'b1;
               state_in    = S_MULX;
            end
         end
         S_MULX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lbsc_pkg::MUL_DX_SW;
            state_in    = S_DIVX;
         end
         S_DIVX: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = lbsc_pkg::DIV_X;
            state_in      = S_WAITX;
         end
         S_WAITX: begin
            if (status.div_done) begin
               cmd.sx_en   = 1'b1;
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = lbsc_pkg::MUL_DY_SH;
               state_in    = S_DIVY;
            end
         end
         S_DIVY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = lbsc_pkg::DIV_Y;
            state_in      = S_WAITY;
         end
         S_WAITY: begin
            if (status.div_done) begin
               cmd.sy_en = 1'b1;
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lbsc_pkg::MUL_SY_SW;
            kind_in     = lbsc_pkg::OUT_PIXEL;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            // hold until the result register has room for this beat
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= lbsc_pkg::OUT_INVALID;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result loaded while previous beat still stalled");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider restarted while busy");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_WAITG || state_ff == S_WAITX ||
                           state_ff == S_WAITY))
      else $error("divider finished outside a wait state");

   a_geom_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GEOM) |=> (running_ff && state_ff == S_PIX))
      else $error("frame not running after geometry setup");

endmodule

// ----- rtl/letterbox_nearest_scaler_addr_core.sv -----
// Top level of the letterbox nearest-neighbor scaler address generator.
// Each req beat yields one rsp beat for the next canvas pixel in raster order.
// Work runs one beat at a time through a shared 11x11 multiplier and a
// one-bit-per-cycle 22-step divider. A border pixel goes from accept through
// the border check to the result register; a pixel inside the window also
// needs two divisions (source column, source row) of 22 steps each and three
// multiplies, the last for the address. A frame start adds the aspect fit
// (two multiplies, a compare, one division); an invalid source size skips it
// and gives an invalid beat. Source size and canvas mode latch at frame start.
module letterbox_nearest_scaler_addr_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_restart_frame,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [lbsc_pkg::XW-1:0]  rsp_dest_x,
   output logic [lbsc_pkg::YW-1:0]  rsp_dest_y,
   output logic [lbsc_pkg::SW-1:0]  rsp_src_x,
   output logic [lbsc_pkg::SW-1:0]  rsp_src_y,
   output logic [lbsc_pkg::AW-1:0]  rsp_src_address,
   output logic                     rsp_is_border,
   output logic                     rsp_frame_invalid,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [lbsc_pkg::SW-1:0]  csr_data
);

   lbsc_pkg::cmd_type    cmd;
   lbsc_pkg::status_type status;

   lbsc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_restart_frame (req_restart_frame),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .status            (status)
   );

   lbsc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_dest_x        (rsp_dest_x),
      .rsp_dest_y        (rsp_dest_y),
      .rsp_src_x         (rsp_src_x),
      .rsp_src_y         (rsp_src_y),
      .rsp_src_address   (rsp_src_address),
      .rsp_is_border     (rsp_is_border),
      .rsp_frame_invalid (rsp_frame_invalid),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule
